// File: rtl/core/ffsa_pkg.sv
// Package for the first-fit segment allocator: operation, status and CSR codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;
   localparam int DataWidth = 32;
   localparam int CsrIndexWidth = 1;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RESERVE = 2'd1,
      OP_FREE    = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_TAKEN = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   localparam logic [CsrIndexWidth-1:0] CSR_TOTAL_BYTES = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_ALLOC   = 1'b1;

   typedef struct packed {
      op_type                 operation;
      logic [DataWidth-1:0]   address;
      logic [DataWidth-1:0]   size;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [DataWidth-1:0]   result_address;
   } rsp_type;
endpackage
`default_nettype wire

// File: rtl/core/ffsa_if.sv
// Valid/ready channel carrying one word of a packed payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface ffsa_if #(parameter int Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ffsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/first_fit_segment_allocator_top.sv
// First-fit segment allocator: segment table in RAM driven by one sequencer.
// Depends on ffsa_pkg, ffsa_if and ffsa_ram.
// A search visits each entry through a read state and a check state, then a split or
// merge shifts the table one entry at a time through shift-read and shift-write states.
// One word in flight at a time; req ready only in idle.
// Reset (synchronous, active high) and clear restore one free segment of total_bytes.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator_top #(
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ffsa_if.sink                                 req,
   ffsa_if.source                               rsp,
   input  wire logic                            csr_write_enable,
   input  wire logic [ffsa_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [ffsa_pkg::DataWidth-1:0]  csr_write_data
);
   import ffsa_pkg::*;

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int EW = 2 * DataWidth + 1;
   localparam logic [CW-1:0] MaxCount = CW'(MAX_SEGMENTS);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_RD    = 9'b000000010,
      S_CHK   = 9'b000000100,
      S_SHR   = 9'b000001000,
      S_SHW   = 9'b000010000,
      S_PUT   = 9'b000100000,
      S_NBR   = 9'b001000000,
      S_NCHK  = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type           state_ff, state_in;
   logic [31:0]         total_ff, total_in, minb_ff, minb_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       hit_ff, hit_in;
   req_type             rq_ff, rq_in;
   rsp_type             rs_ff, rs_in;
   logic                rsv_ff, rsv_in;
   logic [31:0]         n_ff, n_in;
   // pending inserts (up to two) and free phase
   logic [1:0]          pend_ff, pend_in;
   logic [EW-1:0]       ins_ff [2];
   logic [EW-1:0]       ins_in [2];
   logic [CW-1:0]       pos_ff, pos_in;
   logic                shdn_ff, shdn_in;
   logic [1:0]          fph_ff, fph_in;
   logic [EW-1:0]       cur_ff, cur_in;
   logic                clr_ff, clr_in;
   req_type             req_word;

   logic                we;
   logic [AW-1:0]       wa, ra;
   logic [EW-1:0]       wd, rd;

   ffsa_ram #(.Width(EW), .Depth(MAX_SEGMENTS)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd)
   );

   // entry read back is {used, start, length}
   logic        e_used;
   logic [31:0] e_start, e_len;
   logic [32:0] e_end, r_end;
   logic [32:0] lead, trail;
   logic        fit;
   assign req_word = req.data;
   assign e_used  = rd[EW-1];
   assign e_start = rd[2*DataWidth-1:DataWidth];
   assign e_len   = rd[DataWidth-1:0];
   assign e_end   = {1'b0, e_start} + {1'b0, e_len};
   assign r_end   = {1'b0, rq_ff.address} + {1'b0, n_ff};
   assign lead    = {1'b0, rq_ff.address} - {1'b0, e_start};
   assign trail   = e_end - r_end;
   assign fit     = rsv_ff ? (!e_used && e_start <= rq_ff.address && r_end <= e_end)
                           : (!e_used && e_len >= n_ff);

   assign req.ready = (state_ff == S_IDLE) && !clr_ff;
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = rs_ff;

   always_comb begin
      state_in = state_ff; total_in = total_ff; minb_in = minb_ff;
      count_in = count_ff; idx_in = idx_ff; hit_in = hit_ff; rq_in = rq_ff;
      rs_in = rs_ff; rsv_in = rsv_ff; n_in = n_ff; pend_in = pend_ff;
      ins_in = ins_ff; pos_in = pos_ff; shdn_in = shdn_ff; fph_in = fph_ff;
      cur_in = cur_ff; clr_in = 1'b0;
      we = 1'b0; wa = '0; wd = '0; ra = idx_ff[AW-1:0];
      if (clr_ff) begin
         we = 1'b1; wd = {1'b0, 32'd0, total_ff};
      end
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TOTAL_BYTES: total_in = csr_write_data;
            CSR_MIN_ALLOC:   minb_in = csr_write_data;
            default: ;
         endcase
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               rq_in = req_word;
               n_in = (req_word.size < minb_ff) ? minb_ff : req_word.size;
               rsv_in = (req_word.operation == OP_RESERVE);
               idx_in = '0; fph_in = 2'd0;
               rs_in = '{status: ST_OK, result_address: 32'd0};
               if (req_word.operation == OP_CLEAR) begin
                  count_in = CW'(1); clr_in = 1'b1; state_in = S_OUT;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (idx_ff >= count_ff) begin
               if (rq_ff.operation == OP_ALLOC) rs_in.status = ST_NOFIT;
               else if (rq_ff.operation == OP_RESERVE) rs_in.status = ST_TAKEN;
               state_in = S_OUT;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (rq_ff.operation == OP_FREE) begin
               if (e_start == rq_ff.address) begin
                  if (!e_used) state_in = S_OUT;
                  else begin
                     hit_in = idx_ff; cur_in = {1'b0, e_start, e_len};
                     we = 1'b1; wa = idx_ff[AW-1:0]; wd = cur_in;
                     fph_in = 2'd1; idx_in = idx_ff + CW'(1); state_in = S_NBR;
                  end
               end else begin
                  idx_in = idx_ff + CW'(1); state_in = S_RD;
               end
            end else if (fit) begin
               hit_in = idx_ff;
               if (rsv_ff) begin
                  if ({1'b0, count_ff} + CW'(lead != 33'd0) + CW'(trail != 33'd0) >
                      {1'b0, MaxCount}) begin
                     rs_in.status = ST_FULL; state_in = S_OUT;
                  end else begin
                     rs_in.result_address = rq_ff.address;
                     pend_in = 2'd0;
                     if (lead != 33'd0) begin
                        ins_in[0] = {1'b1, rq_ff.address, n_ff};
                        wd = {1'b0, e_start, lead[31:0]};
                        pend_in = 2'd1;
                     end else begin
                        wd = {1'b1, rq_ff.address, n_ff};
                     end
                     we = 1'b1; wa = idx_ff[AW-1:0];
                     if (trail != 33'd0) begin
                        ins_in[pend_in[0]] = {1'b0, r_end[31:0], trail[31:0]};
                        pend_in = pend_in + 2'd1;
                     end
                     pos_in = idx_ff + CW'(1);
                     idx_in = count_ff; shdn_in = 1'b0;
                     state_in = (pend_in == 2'd0) ? S_OUT : S_SHR;
                  end
               end else begin
                  if (e_len > n_ff && count_ff >= MaxCount) begin
                     rs_in.status = ST_FULL; state_in = S_OUT;
                  end else begin
                     rs_in.result_address = e_start;
                     we = 1'b1; wa = idx_ff[AW-1:0]; wd = {1'b1, e_start, n_ff};
                     pend_in = 2'd0;
                     if (e_len > n_ff) begin
                        ins_in[0] = {1'b0, e_start + n_ff, e_len - n_ff};
                        pend_in = 2'd1;
                     end else begin
                        wd = {1'b1, e_start, e_len};
                     end
                     pos_in = idx_ff + CW'(1); idx_in = count_ff; shdn_in = 1'b0;
                     state_in = (pend_in == 2'd0) ? S_OUT : S_SHR;
                  end
               end
            end else begin
               idx_in = idx_ff + CW'(1); state_in = S_RD;
            end
         end
         // shift entries [pos, idx) up by one (shdn=0), or the entries above idx down onto idx (shdn=1)
         S_SHR: begin
            if (!shdn_ff) begin
               if (idx_ff > pos_ff) begin
                  ra = AW'(idx_ff - CW'(1)); state_in = S_SHW;
               end else state_in = S_PUT;
            end else begin
               if (idx_ff + CW'(1) < count_ff) begin
                  ra = AW'(idx_ff + CW'(1)); state_in = S_SHW;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = (fph_ff == 2'd1) ? S_NBR : S_OUT;
                  if (fph_ff == 2'd1) idx_in = hit_ff;
                  fph_in = (fph_ff == 2'd1) ? 2'd2 : fph_ff;
               end
            end
         end
         S_SHW: begin
            we = 1'b1; wa = idx_ff[AW-1:0]; wd = rd;
            idx_in = shdn_ff ? idx_ff + CW'(1) : idx_ff - CW'(1);
            state_in = S_SHR;
         end
         S_PUT: begin
            we = 1'b1; wa = pos_ff[AW-1:0]; wd = ins_ff[0];
            count_in = count_ff + CW'(1);
            ins_in[0] = ins_ff[1];
            pend_in = pend_ff - 2'd1;
            pos_in = pos_ff + CW'(1); idx_in = count_ff + CW'(1);
            state_in = (pend_ff == 2'd1) ? S_OUT : S_SHR;
         end
         // free: phase 1 looks at the entry above, phase 2 at the one below
         S_NBR: begin
            if (fph_ff == 2'd1) begin
               if (idx_ff >= count_ff) begin
                  fph_in = 2'd2; idx_in = hit_ff;
               end else state_in = S_NCHK;
            end else begin
               if (hit_ff == '0) state_in = S_OUT;
               else begin
                  ra = AW'(hit_ff - CW'(1)); state_in = S_NCHK;
               end
            end
         end
         S_NCHK: begin
            if (fph_ff == 2'd1) begin
               if (!e_used) begin
                  cur_in = {1'b0, cur_ff[2*DataWidth-1:DataWidth],
                            cur_ff[DataWidth-1:0] + e_len};
                  we = 1'b1; wa = hit_ff[AW-1:0]; wd = cur_in;
                  idx_in = hit_ff + CW'(1); shdn_in = 1'b1; state_in = S_SHR;
               end else begin
                  fph_in = 2'd2; idx_in = hit_ff; state_in = S_NBR;
               end
            end else begin
               if (!e_used) begin
                  we = 1'b1; wa = AW'(hit_ff - CW'(1));
                  wd = {1'b0, e_start, e_len + cur_ff[DataWidth-1:0]};
                  idx_in = hit_ff; shdn_in = 1'b1; fph_in = 2'd3; state_in = S_SHR;
               end else state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; total_ff <= 32'd1048576; minb_ff <= 32'd32;
         count_ff <= CW'(1); clr_ff <= 1'b1; pend_ff <= '0; fph_ff <= '0;
         shdn_ff <= 1'b0;
      end else begin
         state_ff <= state_in; total_ff <= total_in; minb_ff <= minb_in;
         count_ff <= count_in; clr_ff <= clr_in; pend_ff <= pend_in; fph_ff <= fph_in;
         shdn_ff <= shdn_in;
      end
      idx_ff <= idx_in; hit_ff <= hit_in; rq_ff <= rq_in; rs_ff <= rs_in;
      rsv_ff <= rsv_in; n_ff <= n_in; ins_ff <= ins_in; pos_ff <= pos_in;
      cur_ff <= cur_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(1) && count_ff <= MaxCount)
      else $error("segment count out of range");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response dropped while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while response pending");
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rs_ff.status != ST_OK |-> rs_ff.result_address == 32'd0)
      else $error("failed result carries an address");
endmodule
`default_nettype wire
